[hw/rtl/rc4_pkg.sv]
// Shared constants, command and status codes, and payload types of the RC4 cipher block.
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_DEPTH        = 256;
    localparam int KEY_MAX_BYTES     = 16;
    localparam int KEY_IDX_W         = $clog2(KEY_MAX_BYTES);
    localparam int KEY_BYTES_DEF     = 16;
    localparam int DISCARD_COUNT_DEF = 1024;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    // Register index, taken from paddr[4:3] (registers sit on 8-byte boundaries).
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SKIP_DISCARD = 2'd2;

    localparam logic CMD_LOAD_KEY = 1'b0;
    localparam logic CMD_CRYPT    = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_KEY = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data_in;
        logic              last_in;
    } rc4_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              status;
        logic              last_out;
    } rc4_result_t;

endpackage

[hw/rtl/rc4_stream_if.sv]
// Valid/ready stream channel carrying one payload per transfer.
interface rc4_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/rc4_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rc4_stream_cipher.sv]
// Top level of the RC4 stream cipher with early keystream discard.
//
// The block takes one item at a time on the item channel and returns exactly one
// result on the result channel for each. A crypt item (cmd = 1) XORs data_in with the
// next keystream byte; it steps through S_PR_RD_J, S_PR_WR_I and S_PR_WR_J before its
// result is loaded into the output register, and no new item is taken until the block
// is back in S_IDLE. A crypt item before any key load is answered from S_IDLE through
// the output register with status 1 and zero data, and leaves the indices and the key
// state untouched. A key-load item (cmd = 0) rebuilds the permutation from the key
// registers: an identity fill, the 256 schedule steps, and, unless skip_discard is set,
// DISCARD_COUNT dropped keystream bytes, before its result (zero data, status 0)
// appears. The sequencing follows from the permutation living in one RAM with a single
// registered read port and a single write port: each swap needs two dependent reads and
// two writes. A finished result waits in the output register while the block goes on
// taking the next item; if that register is still full when the next result is ready,
// the block holds until it drains. Configuration is an APB-style port with 64-bit data:
// key_low at byte 0x00, key_high at 0x08, skip_discard at 0x10; pready is always high
// and writes are taken at the access phase. Key reloads are allowed at any time the
// block is idle. There is no clearing pass after reset: the table is filled by the key
// load itself, and nothing reads it before one.
module rc4_stream_cipher #(
    parameter int KEY_BYTES     = rc4_pkg::KEY_BYTES_DEF,
    parameter int DISCARD_COUNT = rc4_pkg::DISCARD_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rc4_stream_if.sink                      item,
    rc4_stream_if.source                    result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rc4_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rc4_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rc4_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import rc4_pkg::*;

    localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int CW = $clog2(DISCARD_COUNT + 2);
    localparam int AW = $clog2(PERM_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_INIT    = 11'b000_0000_0010,
        S_KS_RD_N = 11'b000_0000_0100,
        S_KS_RD_J = 11'b000_0000_1000,
        S_KS_WR_N = 11'b000_0001_0000,
        S_KS_WR_J = 11'b000_0010_0000,
        S_PR_RD_I = 11'b000_0100_0000,
        S_PR_RD_J = 11'b000_1000_0000,
        S_PR_WR_I = 11'b001_0000_0000,
        S_PR_WR_J = 11'b010_0000_0000,
        S_DELIVER = 11'b100_0000_0000
    } state_t;

    // Configuration registers.
    logic [APB_DATA_W-1:0] key_low_reg;
    logic [APB_DATA_W-1:0] key_high_reg;
    logic                  skip_discard_reg;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  cfg_idx;

    // Control state.
    state_t         state_reg, state_next;
    logic [AW-1:0]  i_reg, i_next;
    logic [AW-1:0]  j_reg, j_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           key_ready_reg, key_ready_next;
    logic           out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic              hit_i_reg, hit_i_next;
    logic              hit_j_reg, hit_j_next;
    rc4_result_t       res_reg, res_next;
    rc4_result_t       out_payload_reg, out_payload_next;

    // Working signals.
    logic [BYTE_W-1:0] key_bytes [KEY_MAX_BYTES];
    logic [KEY_IDX_W-1:0] k_idx;
    logic [BYTE_W-1:0] key_byte;
    logic [AW-1:0]     i_inc;
    logic [KW-1:0]     k_wrap;
    logic [AW-1:0]     sum_idx;
    logic [BYTE_W-1:0] ks_byte;
    logic              accept;
    logic              fin;
    rc4_result_t       fin_res;

    // Permutation RAM ports.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Configuration port. Registers are decoded on paddr[4:3]; index 3 is unused.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg      <= '0;
            key_high_reg     <= '0;
            skip_discard_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_KEY_LOW:      key_low_reg      <= pwdata;
                REG_KEY_HIGH:     key_high_reg     <= pwdata;
                REG_SKIP_DISCARD: skip_discard_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_KEY_LOW:      prdata = key_low_reg;
            REG_KEY_HIGH:     prdata = key_high_reg;
            REG_SKIP_DISCARD: prdata = {{(APB_DATA_W-1){1'b0}}, skip_discard_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Key byte selection. The schedule cycles through the first KEY_BYTES bytes.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int b = 0; b < KEY_MAX_BYTES / 2; b++)
        begin
            key_bytes[b]                     = key_low_reg[BYTE_W*b +: BYTE_W];
            key_bytes[b + KEY_MAX_BYTES / 2] = key_high_reg[BYTE_W*b +: BYTE_W];
        end
    end

    assign k_idx    = KEY_IDX_W'(k_reg);
    assign key_byte = key_bytes[k_idx];
    assign k_wrap   = (k_reg == KW'(KEY_BYTES - 1)) ? '0 : k_reg + KW'(1);
    assign i_inc    = i_reg + AW'(1);

    // Forwarding for the final lookup: the read of S[a+b] is issued in the same cycle
    // that S[i] is written, and before S[j] is written, so it may see stale
    // data. The later write (S[j] = a) takes precedence when i and j coincide.
    assign ks_byte = hit_j_reg ? a_reg : (hit_i_reg ? b_reg : ram_rdata);

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

    // ------------------------------------------------------------------
    // Sequencer. Each swap is read S[x], read S[y], write S[x], write S[y].
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        cnt_next         = cnt_reg;
        key_ready_next   = key_ready_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        data_next        = data_reg;
        last_next        = last_reg;
        hit_i_next       = hit_i_reg;
        hit_j_next       = hit_j_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_payload_next = out_payload_reg;
        ram_we           = 1'b0;
        ram_waddr        = i_reg;
        ram_wdata        = a_reg;
        ram_raddr        = i_reg;
        sum_idx          = '0;
        fin              = 1'b0;
        fin_res          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next = item.payload.data_in;
                    last_next = item.payload.last_in;
                    if (item.payload.cmd == CMD_LOAD_KEY)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = S_INIT;
                    end
                    else if (!key_ready_reg)
                    begin
                        fin     = 1'b1;
                        fin_res = '{data_out: '0, status: STATUS_NO_KEY,
                                    last_out: item.payload.last_in};
                    end
                    else
                    begin
                        // First read of the keystream step is issued right away.
                        ram_raddr  = i_inc;
                        i_next     = i_inc;
                        state_next = S_PR_RD_J;
                    end
                end
            end

            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = i_reg;
                i_next    = i_inc;
                if (i_reg == AW'(PERM_DEPTH - 1))
                begin
                    state_next = S_KS_RD_N;
                end
            end

            S_KS_RD_N:
            begin
                ram_raddr  = i_reg;
                state_next = S_KS_RD_J;
            end

            S_KS_RD_J:
            begin
                a_next     = ram_rdata;
                sum_idx    = j_reg + key_byte + ram_rdata;
                j_next     = sum_idx;
                ram_raddr  = sum_idx;
                state_next = S_KS_WR_N;
            end

            S_KS_WR_N:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                state_next = S_KS_WR_J;
            end

            S_KS_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = a_reg;
                i_next    = i_inc;
                k_next    = k_wrap;
                if (i_reg == AW'(PERM_DEPTH - 1))
                begin
                    // Schedule done; i has wrapped to zero, j restarts at zero.
                    j_next         = '0;
                    key_ready_next = 1'b1;
                    if (skip_discard_reg || (DISCARD_COUNT == 0))
                    begin
                        fin     = 1'b1;
                        fin_res = '{data_out: '0, status: STATUS_OK, last_out: last_reg};
                    end
                    else
                    begin
                        cnt_next   = CW'(DISCARD_COUNT);
                        state_next = S_PR_RD_I;
                    end
                end
                else
                begin
                    state_next = S_KS_RD_N;
                end
            end

            S_PR_RD_I:
            begin
                ram_raddr  = i_inc;
                i_next     = i_inc;
                state_next = S_PR_RD_J;
            end

            S_PR_RD_J:
            begin
                a_next     = ram_rdata;
                sum_idx    = j_reg + ram_rdata;
                j_next     = sum_idx;
                ram_raddr  = sum_idx;
                state_next = S_PR_WR_I;
            end

            S_PR_WR_I:
            begin
                b_next     = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                sum_idx    = a_reg + ram_rdata;
                ram_raddr  = sum_idx;
                hit_i_next = (sum_idx == i_reg);
                hit_j_next = (sum_idx == j_reg);
                state_next = S_PR_WR_J;
            end

            S_PR_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = a_reg;
                if (cnt_reg != '0)
                begin
                    // Discarded keystream byte following a key load.
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        fin     = 1'b1;
                        fin_res = '{data_out: '0, status: STATUS_OK, last_out: last_reg};
                    end
                    else
                    begin
                        state_next = S_PR_RD_I;
                    end
                end
                else
                begin
                    fin     = 1'b1;
                    fin_res = '{data_out: data_reg ^ ks_byte, status: STATUS_OK,
                                last_out: last_reg};
                end
            end

            S_DELIVER:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_payload_next = res_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free,
        // otherwise it is parked until the register drains.
        if (fin)
        begin
            if (!out_valid_reg || result.ready)
            begin
                out_valid_next   = 1'b1;
                out_payload_next = fin_res;
                state_next       = S_IDLE;
            end
            else
            begin
                res_next   = fin_res;
                state_next = S_DELIVER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            key_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            key_ready_reg <= key_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg           <= a_next;
        b_reg           <= b_next;
        data_reg        <= data_next;
        last_reg        <= last_next;
        hit_i_reg       <= hit_i_next;
        hit_j_reg       <= hit_j_next;
        res_reg         <= res_next;
        out_payload_reg <= out_payload_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The last schedule step leaves both indices at zero and the key marked ready.
    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KS_WR_J) && (i_reg == AW'(PERM_DEPTH - 1))
        |=> (i_reg == '0) && (j_reg == '0) && key_ready_reg)
        else $error("key schedule did not end with cleared indices");

    // A crypt item without a key must leave the indices untouched.
    a_no_key_stable: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.payload.cmd == CMD_CRYPT) && !key_ready_reg
        |=> $stable(i_reg) && $stable(j_reg) && $stable(key_ready_reg))
        else $error("crypt without key changed cipher state");

    // The discard counter only runs during keystream steps.
    a_discard_scope: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (state_reg == S_PR_RD_I) || (state_reg == S_PR_RD_J) ||
                            (state_reg == S_PR_WR_I) || (state_reg == S_PR_WR_J))
        else $error("discard counter active outside keystream steps");

    // A result is parked only while the output register holds an earlier one.
    a_park_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELIVER) |-> out_valid_reg)
        else $error("result parked while output register was empty");

    // An error result always carries zero data.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_payload_reg.status == STATUS_NO_KEY)
        |-> (out_payload_reg.data_out == '0))
        else $error("error result carries nonzero data");

endmodule
